// ===== sv/fbflc_pkg.sv =====
// Shared constants, codes and control structures of the free list cache.
`timescale 1ns / 1ps

package fbflc_pkg;

  localparam int CACHE_DEPTH = 16;
  localparam int ADDR_W      = 48;

  localparam int CNT_W = $clog2(CACHE_DEPTH + 1);
  localparam int IDX_W = (CACHE_DEPTH > 1) ? $clog2(CACHE_DEPTH) : 1;
  localparam int CMP_W = (CNT_W > 5) ? CNT_W : 5;

  localparam int SIZE_W      = 16;
  localparam int ALIGN_W     = 13;
  localparam int ALOG_W      = 4;
  localparam int LIMIT_W     = 5;
  localparam int ABYTES_W    = 17;
  localparam int STATUS_W    = 3;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;

  localparam int IN_FIELDS_W  = SIZE_W + ALIGN_W + ADDR_W;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = ADDR_W + SIZE_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam logic [SIZE_W-1:0]  BLOCK_SIZE_RST = 16'd64;
  localparam logic [ALOG_W-1:0]  ALIGN_LOG2_RST = 4'd3;
  localparam logic [LIMIT_W-1:0] CACHE_LIMIT_RST = 5'd16;

  typedef enum logic [STATUS_W-1:0] {
    ST_FROM_CACHE  = 3'd0,
    ST_FORWARD     = 3'd1,
    ST_INVALID     = 3'd2,
    ST_CACHED      = 3'd3,
    ST_RELEASE     = 3'd4,
    ST_MISALIGNED  = 3'd5,
    ST_DOUBLE_FREE = 3'd6,
    ST_NULL        = 3'd7
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BLOCK_SIZE  = 2'd0,
    CFG_ALIGN_LOG2  = 2'd1,
    CFG_CACHE_LIMIT = 2'd2,
    CFG_HARDENED    = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic    item_load;
    logic    pop_rd;
    logic    scan_clear;
    logic    scan;
    logic    push;
    logic    pop;
    logic    res_load;
    status_e res_code;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic op_free;
    logic alloc_bad;
    logic nonempty;
    logic is_null;
    logic misaligned;
    logic hardened;
    logic can_push;
    logic scan_hit;
    logic scan_done;
    logic out_busy;
  } stat_t;

endpackage

// ===== sv/fbflc_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
`timescale 1ns / 1ps

module fbflc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic                                     re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== sv/fbflc_ctrl.sv =====
// Controller state machine that sequences checks, cache scan and updates.
`timescale 1ns / 1ps

module fbflc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_valid_i,
  output logic                s_ready_o,
  input  fbflc_pkg::stat_t    stat_i,
  output fbflc_pkg::cmd_t     cmd_o
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_DECIDE = 6'b000010,
    S_POP    = 6'b000100,
    S_SCAN   = 6'b001000,
    S_INSERT = 6'b010000,
    S_FINISH = 6'b100000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d   = state_q;
    cmd_o     = '0;
    s_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          cmd_o.item_load = 1'b1;
          state_d         = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd_o.scan_clear = 1'b1;
        priority if (!stat_i.op_free && stat_i.alloc_bad) begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_code = fbflc_pkg::ST_INVALID;
          state_d        = S_FINISH;
        end else if (!stat_i.op_free && stat_i.nonempty) begin
          cmd_o.pop_rd = 1'b1;
          state_d      = S_POP;
        end else if (!stat_i.op_free) begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_code = fbflc_pkg::ST_FORWARD;
          state_d        = S_FINISH;
        end else if (stat_i.is_null) begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_code = fbflc_pkg::ST_NULL;
          state_d        = S_FINISH;
        end else if (stat_i.hardened && stat_i.misaligned) begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_code = fbflc_pkg::ST_MISALIGNED;
          state_d        = S_FINISH;
        end else if (stat_i.hardened) begin
          state_d = S_SCAN;
        end else begin
          state_d = S_INSERT;
        end
      end
      S_POP: begin
        cmd_o.pop      = 1'b1;
        cmd_o.res_load = 1'b1;
        cmd_o.res_code = fbflc_pkg::ST_FROM_CACHE;
        state_d        = S_FINISH;
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        priority if (stat_i.scan_hit) begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_code = fbflc_pkg::ST_DOUBLE_FREE;
          state_d        = S_FINISH;
        end else if (stat_i.scan_done) begin
          state_d = S_INSERT;
        end else begin
          state_d = S_SCAN;
        end
      end
      S_INSERT: begin
        cmd_o.res_load = 1'b1;
        if (stat_i.can_push) begin
          cmd_o.push     = 1'b1;
          cmd_o.res_code = fbflc_pkg::ST_CACHED;
        end else begin
          cmd_o.res_code = fbflc_pkg::ST_RELEASE;
        end
        state_d = S_FINISH;
      end
      S_FINISH: begin
        if (!stat_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== sv/fbflc_dp.sv =====
// Datapath: configuration, request registers, address cache and result registers.
`timescale 1ns / 1ps

module fbflc_dp (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [fbflc_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [fbflc_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic [fbflc_pkg::IN_TDATA_W-1:0]      s_tdata_i,
  input  logic                                  s_tuser_i,
  output logic                                  m_tvalid_o,
  input  logic                                  m_tready_i,
  output logic [fbflc_pkg::OUT_TDATA_W-1:0]     m_tdata_o,
  output logic [fbflc_pkg::STATUS_W-1:0]        m_tuser_o,
  input  fbflc_pkg::cmd_t                       cmd_i,
  output fbflc_pkg::stat_t                      stat_o
);

  localparam int AW = fbflc_pkg::ADDR_W;
  localparam int SW = fbflc_pkg::SIZE_W;
  localparam int ALW = fbflc_pkg::ALIGN_W;
  localparam int CW = fbflc_pkg::CNT_W;
  localparam int IW = fbflc_pkg::IDX_W;
  localparam int MW = fbflc_pkg::CMP_W;
  localparam int BW = fbflc_pkg::ABYTES_W;

  logic [SW-1:0]                    block_size_q;
  logic [fbflc_pkg::ALOG_W-1:0]     align_log2_q;
  logic [fbflc_pkg::LIMIT_W-1:0]    cache_limit_q;
  logic                             hardened_q;

  logic                             op_q;
  logic [SW-1:0]                    size_q;
  logic [ALW-1:0]                   align_q;
  logic [AW-1:0]                    addr_q;

  logic [CW-1:0]                    count_q, count_d;
  logic [CW-1:0]                    scan_rd_q, scan_rd_d;
  logic                             cmp_pending_q, cmp_pending_d;
  logic [CW-1:0]                    pop_idx;
  logic                             scan_issue;

  logic                             ram_re;
  logic [IW-1:0]                    ram_raddr;
  logic [AW-1:0]                    ram_rdata;

  logic [BW-1:0]                    align_bytes;
  logic [AW-1:0]                    addr_mask;
  logic [MW-1:0]                    lim_ext, depth_ext, eff_limit;

  logic [fbflc_pkg::STATUS_W-1:0]   res_status_q;
  logic [AW-1:0]                    res_addr_q;
  logic [SW-1:0]                    res_size_q;

  logic                             out_valid_q;
  logic [fbflc_pkg::STATUS_W-1:0]   out_status_q;
  logic [AW-1:0]                    out_addr_q;
  logic [SW-1:0]                    out_size_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_size_q  <= fbflc_pkg::BLOCK_SIZE_RST;
      align_log2_q  <= fbflc_pkg::ALIGN_LOG2_RST;
      cache_limit_q <= fbflc_pkg::CACHE_LIMIT_RST;
      hardened_q    <= 1'b1;
    end else if (cfg_valid_i) begin
      unique case (fbflc_pkg::cfg_idx_e'(cfg_index_i))
        fbflc_pkg::CFG_BLOCK_SIZE:  block_size_q  <= cfg_data_i[SW-1:0];
        fbflc_pkg::CFG_ALIGN_LOG2:  align_log2_q  <= cfg_data_i[fbflc_pkg::ALOG_W-1:0];
        fbflc_pkg::CFG_CACHE_LIMIT: cache_limit_q <= cfg_data_i[fbflc_pkg::LIMIT_W-1:0];
        fbflc_pkg::CFG_HARDENED:    hardened_q    <= cfg_data_i[0];
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.item_load) begin
      op_q    <= s_tuser_i;
      size_q  <= s_tdata_i[SW-1:0];
      align_q <= s_tdata_i[SW+ALW-1:SW];
      addr_q  <= s_tdata_i[SW+ALW+AW-1:SW+ALW];
    end
  end

  // Request checks.
  assign align_bytes = BW'(1) << align_log2_q;
  assign addr_mask   = ~({AW{1'b1}} << align_log2_q);
  assign lim_ext     = MW'(cache_limit_q);
  assign depth_ext   = MW'(fbflc_pkg::CACHE_DEPTH);
  assign eff_limit   = (lim_ext < depth_ext) ? lim_ext : depth_ext;

  assign stat_o.op_free    = op_q;
  assign stat_o.alloc_bad  = (block_size_q == '0) || (size_q != block_size_q) ||
                             (BW'(align_q) > align_bytes);
  assign stat_o.nonempty   = (count_q != '0);
  assign stat_o.is_null    = (addr_q == '0);
  assign stat_o.misaligned = |(addr_q & addr_mask);
  assign stat_o.hardened   = hardened_q;
  assign stat_o.can_push   = (MW'(count_q) < eff_limit);
  assign stat_o.scan_hit   = cmp_pending_q && (ram_rdata == addr_q);
  assign stat_o.scan_done  = !cmp_pending_q && (scan_rd_q == count_q);
  assign stat_o.out_busy   = out_valid_q && !m_tready_i;

  // The scan issues one read per cycle and compares the word returned in the next cycle.
  assign pop_idx    = count_q - CW'(1);
  assign scan_issue = cmd_i.scan && (scan_rd_q != count_q);
  assign ram_re     = cmd_i.pop_rd || scan_issue;
  assign ram_raddr  = cmd_i.scan ? scan_rd_q[IW-1:0] : pop_idx[IW-1:0];

  always_comb begin
    scan_rd_d     = scan_rd_q;
    cmp_pending_d = cmp_pending_q;
    if (cmd_i.scan_clear) begin
      scan_rd_d     = '0;
      cmp_pending_d = 1'b0;
    end else if (cmd_i.scan) begin
      cmp_pending_d = scan_issue;
      if (scan_issue) begin
        scan_rd_d = scan_rd_q + CW'(1);
      end
    end
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.push) begin
      count_d = count_q + CW'(1);
    end else if (cmd_i.pop) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q       <= '0;
      scan_rd_q     <= '0;
      cmp_pending_q <= 1'b0;
    end else begin
      count_q       <= count_d;
      scan_rd_q     <= scan_rd_d;
      cmp_pending_q <= cmp_pending_d;
    end
  end

  fbflc_ram #(
    .WIDTH(AW),
    .DEPTH(fbflc_pkg::CACHE_DEPTH)
  ) u_cache_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.push),
    .waddr_i(count_q[IW-1:0]),
    .wdata_i(addr_q),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      res_status_q <= cmd_i.res_code;
      if (cmd_i.res_code == fbflc_pkg::ST_FROM_CACHE) begin
        res_addr_q <= ram_rdata;
        res_size_q <= block_size_q;
      end else begin
        res_addr_q <= '0;
        res_size_q <= '0;
      end
    end
    if (cmd_i.out_load) begin
      out_status_q <= res_status_q;
      out_addr_q   <= res_addr_q;
      out_size_q   <= res_size_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tuser_o  = out_status_q;
  assign m_tdata_o  = {{(fbflc_pkg::OUT_TDATA_W - fbflc_pkg::OUT_FIELDS_W){1'b0}},
                       out_size_q, out_addr_q};

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(fbflc_pkg::CACHE_DEPTH))
    else $error("cache count exceeds depth");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.push |-> (MW'(count_q) < eff_limit))
    else $error("push into a full cache");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pop |-> (count_q != '0))
    else $error("pop from an empty cache");

  a_pop_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pop |=> (count_q == $past(count_q) - CW'(1)))
    else $error("pop did not decrement the count");

  a_out_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> !(out_valid_q && !m_tready_i))
    else $error("result word overwritten while stalled");

endmodule

// ===== sv/fixed_block_free_list_cache.sv =====
// Top level of the fixed-size block pool with a cache of freed addresses.
//
// Requests arrive as words on the s_axis channel: tuser carries the operation
// (0 allocate, 1 free) and tdata carries size, alignment and block address.
// Each request yields exactly one word on the m_axis channel: tuser holds the
// status code and tdata the popped address and block size, or zeros if none.
// Registers are written through the cfg channel, which is always ready; they
// may only be changed while no request is in flight.
// One request is worked on at a time. An allocate passes the decide and finish
// states, with a pop state between them when it is served from the cache; a
// null or misaligned free passes decide and finish, a non-hardened free decide,
// insert and finish. A hardened free walks the cached addresses one RAM read
// per cycle in a scan state before insert, and goes to finish at once when a
// double free is found. The next request is accepted in the cycle after the
// result is loaded.
// A finished result sits in an output register, so the next request is taken
// while the receiver stalls; a second finished result waits until the first
// one has been taken. Reset empties the cache count, restores the register
// reset values and leaves the address RAM contents undefined.
`timescale 1ns / 1ps

module fixed_block_free_list_cache (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [fbflc_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [fbflc_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // Fields from bit 0: req_size, req_align, block_addr, zero fill.
  input  logic [fbflc_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // Fields from bit 0: op.
  input  logic                                 s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // Fields from bit 0: addr_out, size_out, zero fill.
  output logic [fbflc_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  // Fields from bit 0: status.
  output logic [fbflc_pkg::STATUS_W-1:0]       m_axis_tuser
);

  fbflc_pkg::cmd_t  cmd;
  fbflc_pkg::stat_t stat;

  fbflc_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .s_valid_i(s_axis_tvalid),
    .s_ready_o(s_axis_tready),
    .stat_i   (stat),
    .cmd_o    (cmd)
  );

  fbflc_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .s_tdata_i  (s_axis_tdata),
    .s_tuser_i  (s_axis_tuser),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .m_tdata_o  (m_axis_tdata),
    .m_tuser_o  (m_axis_tuser),
    .cmd_i      (cmd),
    .stat_o     (stat)
  );

endmodule
